// ----- design/zep_pkg.sv -----
// ----------------------------------------------------------------------------
// zep_pkg
// Shared types and constants for the zone edge proximity engine.
// ----------------------------------------------------------------------------
package zep_pkg;

  localparam int ZONE_SLOTS = 16;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_BOUNDS = 2'd2;

  localparam logic [3:0] CFG_ZONE_COUNT     = 4'd0;
  localparam logic [3:0] CFG_NEAR_THRESHOLD = 4'd1;

  localparam logic [14:0] THRESHOLD_RESET = 15'd20;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         zone_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic [14:0]        extent_w;
    logic [14:0]        extent_h;
    logic [15:0]        zone_mask;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         result_index;
    logic               found;
    logic               last;
    logic signed [15:0] bound_x;
    logic signed [15:0] bound_y;
    logic [15:0]        bound_w;
    logic [15:0]        bound_h;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  reg_index;
    logic [15:0] value;
  } cfg_word_t;

  typedef struct packed {
    logic                       valid;
    logic                       bounds;
    logic signed [15:0]         px;
    logic signed [15:0]         py;
    logic [ZONE_SLOTS-1:0]      mask;
    logic [ZONE_SLOTS-1:0]      hits;
    logic                       any;
    logic signed [15:0]         mnx;
    logic signed [15:0]         mny;
    logic signed [16:0]         mxx;
    logic signed [16:0]         mxy;
  } chain_word_t;

endpackage

// ----- design/zep_stream_if.sv -----
// ----------------------------------------------------------------------------
// zep_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface zep_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/zep_cell.sv -----
// ----------------------------------------------------------------------------
// zep_cell
// One zone entry of the chain: tests the passing word against its zone and
// hands the updated word to the next cell.
// ----------------------------------------------------------------------------
module zep_cell #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_en,
  input  zep_pkg::in_word_t    load_word,
  input  logic [14:0]          threshold,
  input  logic                 active,
  input  zep_pkg::chain_word_t word_in,
  output zep_pkg::chain_word_t word_out
);

  logic signed [15:0] left_r;
  logic signed [15:0] top_r;
  logic signed [16:0] right_r;
  logic signed [16:0] bot_r;

  zep_pkg::chain_word_t word_r;
  zep_pkg::chain_word_t word_nxt;

  logic signed [16:0] px_e;
  logic signed [16:0] py_e;
  logic signed [16:0] left_e;
  logic signed [16:0] top_e;
  logic signed [15:0] mnx_i;
  logic signed [15:0] mny_i;
  logic signed [16:0] mxx_i;
  logic signed [16:0] mxy_i;
  logic               horiz_edge;
  logic               vert_edge;
  logic               in_v;
  logic               in_h;
  logic               hit;

  function automatic logic is_near(logic signed [16:0] a, logic signed [16:0] b,
                                   logic [14:0] thr);
    logic signed [17:0] d;
    logic [17:0]        mag;
    d   = 18'($signed({a[16], a})) - 18'($signed({b[16], b}));
    mag = d[17] ? 18'(-d) : 18'(d);
    return mag < {3'b000, thr};
  endfunction

  always_ff @(posedge clk) begin
    if (load_en) begin
      left_r  <= load_word.coord_x;
      top_r   <= load_word.coord_y;
      right_r <= {load_word.coord_x[15], load_word.coord_x} + {2'b00, load_word.extent_w};
      bot_r   <= {load_word.coord_y[15], load_word.coord_y} + {2'b00, load_word.extent_h};
    end
  end

  assign px_e   = {word_in.px[15], word_in.px};
  assign py_e   = {word_in.py[15], word_in.py};
  assign left_e = {left_r[15], left_r};
  assign top_e  = {top_r[15], top_r};
  assign mnx_i  = word_in.mnx;
  assign mny_i  = word_in.mny;
  assign mxx_i  = word_in.mxx;
  assign mxy_i  = word_in.mxy;

  assign horiz_edge = is_near(px_e, left_e, threshold) || is_near(px_e, right_r, threshold);
  assign vert_edge  = is_near(py_e, top_e, threshold) || is_near(py_e, bot_r, threshold);
  assign in_v       = (py_e >= top_e) && (py_e <= bot_r);
  assign in_h       = (px_e >= left_e) && (px_e <= right_r);
  assign hit        = (horiz_edge && in_v) || (vert_edge && in_h);

  always_comb begin
    word_nxt = word_in;
    if (word_in.valid && active) begin
      if (!word_in.bounds) begin
        word_nxt.hits[IDX] = hit;
      end else if (word_in.mask[IDX]) begin
        word_nxt.any = 1'b1;
        if (!word_in.any) begin
          word_nxt.mnx = left_r;
          word_nxt.mny = top_r;
          word_nxt.mxx = right_r;
          word_nxt.mxy = bot_r;
        end else begin
          if (left_r < mnx_i) word_nxt.mnx = left_r;
          if (top_r < mny_i) word_nxt.mny = top_r;
          if (right_r > mxx_i) word_nxt.mxx = right_r;
          if (bot_r > mxy_i) word_nxt.mxy = bot_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign word_out = word_r;

endmodule

// ----- design/zep_emit.sv -----
// ----------------------------------------------------------------------------
// zep_emit
// Turns the word leaving the chain into result words, one per cycle while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module zep_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  zep_pkg::chain_word_t word_in,
  input  logic                 out_ready,
  output logic                 out_valid,
  output zep_pkg::out_word_t   out_data,
  output logic                 busy
);

  localparam int SLOTS = zep_pkg::ZONE_SLOTS;

  logic                  pending_r;
  logic                  pending_nxt;
  logic                  bounds_r;
  logic                  found_r;
  logic [SLOTS-1:0]      hits_r;
  logic [SLOTS-1:0]      hits_nxt;
  logic signed [15:0]    bx_r;
  logic signed [15:0]    by_r;
  logic [15:0]           bw_r;
  logic [15:0]           bh_r;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  zep_pkg::out_word_t    out_data_r;
  zep_pkg::out_word_t    out_data_nxt;

  logic signed [17:0]    dw;
  logic signed [17:0]    dh;
  logic [3:0]            low_idx;
  logic [SLOTS-1:0]      rest;
  logic                  load_out;

  assign dw = $signed({word_in.mxx[16], word_in.mxx})
            - $signed({word_in.mnx[15], word_in.mnx[15], word_in.mnx});
  assign dh = $signed({word_in.mxy[16], word_in.mxy})
            - $signed({word_in.mny[15], word_in.mny[15], word_in.mny});

  always_comb begin
    low_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hits_r[i]) low_idx = 4'(i);
    end
  end

  assign rest     = hits_r & (hits_r - 1'b1);
  assign load_out = pending_r && (!out_valid_r || out_ready);

  always_comb begin
    pending_nxt   = pending_r;
    hits_nxt      = hits_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      if (bounds_r) begin
        out_data_nxt.found   = found_r;
        out_data_nxt.last    = 1'b1;
        out_data_nxt.bound_x = bx_r;
        out_data_nxt.bound_y = by_r;
        out_data_nxt.bound_w = bw_r;
        out_data_nxt.bound_h = bh_r;
        pending_nxt          = 1'b0;
      end else if (hits_r == '0) begin
        out_data_nxt.last = 1'b1;
        pending_nxt       = 1'b0;
      end else begin
        out_data_nxt.result_index = low_idx;
        out_data_nxt.found        = 1'b1;
        out_data_nxt.last         = (rest == '0);
        hits_nxt                  = rest;
        pending_nxt               = (rest != '0);
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (word_in.valid) begin
      pending_nxt = 1'b1;
      hits_nxt    = word_in.hits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hits_r     <= hits_nxt;
    out_data_r <= out_data_nxt;
    if (word_in.valid) begin
      bounds_r <= word_in.bounds;
      found_r  <= word_in.any;
      bx_r     <= word_in.any ? word_in.mnx : 16'sd0;
      by_r     <= word_in.any ? word_in.mny : 16'sd0;
      bw_r     <= !word_in.any ? 16'd0 : ((dw[17:16] != 2'b00) ? 16'hFFFF : dw[15:0]);
      bh_r     <= !word_in.any ? 16'd0 : ((dh[17:16] != 2'b00) ? 16'hFFFF : dh[15:0]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign busy      = pending_r;

endmodule

// ----- design/zone_edge_proximity_engine.sv -----
// ----------------------------------------------------------------------------
// zone_edge_proximity_engine
// Zone table held in a chain of cells; queries and bounds words walk the chain.
// ----------------------------------------------------------------------------
// Flow: a query or bounds word passes the min(MAX_ZONES,16) cell registers
// and then the emitter's pending and output registers; further query results
// follow one per cycle while out_ch is ready. Any new word, a load as well, is
// taken only once the chain is empty and no results are pending.
// Reset: zone_count clears to 0, near_threshold returns to 20; the zone table
// holds its contents and must be loaded before use.
module zone_edge_proximity_engine #(
  parameter int MAX_ZONES = 16
) (
  input logic          clk,
  input logic          rst_n,
  zep_stream_if.sink   in_ch,
  zep_stream_if.source out_ch,
  zep_stream_if.sink   cfg_ch
);

  localparam int NCELL = (MAX_ZONES < zep_pkg::ZONE_SLOTS) ? MAX_ZONES : zep_pkg::ZONE_SLOTS;

  logic [4:0]           zone_count_r;
  logic [14:0]          near_threshold_r;
  zep_pkg::in_word_t    in_word;
  zep_pkg::cfg_word_t   cfg_word;
  zep_pkg::chain_word_t head_word;
  zep_pkg::chain_word_t link [NCELL+1];
  logic [NCELL-1:0]     stage_valid;
  logic                 emit_busy;
  logic                 accept;
  logic                 load_hit;

  assign in_word  = in_ch.data;
  assign cfg_word = cfg_ch.data;

  assign in_ch.ready  = !(|stage_valid) && !emit_busy;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign load_hit     = accept && (in_word.op == zep_pkg::OP_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_count_r     <= '0;
      near_threshold_r <= zep_pkg::THRESHOLD_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_word.reg_index)
        zep_pkg::CFG_ZONE_COUNT:     zone_count_r     <= cfg_word.value[4:0];
        zep_pkg::CFG_NEAR_THRESHOLD: near_threshold_r <= cfg_word.value[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    head_word        = '0;
    head_word.valid  = accept && ((in_word.op == zep_pkg::OP_QUERY) ||
                                  (in_word.op == zep_pkg::OP_BOUNDS));
    head_word.bounds = (in_word.op == zep_pkg::OP_BOUNDS);
    head_word.px     = in_word.coord_x;
    head_word.py     = in_word.coord_y;
    head_word.mask   = in_word.zone_mask;
  end

  assign link[0] = head_word;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    zep_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load_en   (load_hit && (in_word.zone_index == 4'(g))),
      .load_word (in_word),
      .threshold (near_threshold_r),
      .active    (5'(g) < zone_count_r),
      .word_in   (link[g]),
      .word_out  (link[g+1])
    );
    assign stage_valid[g] = link[g+1].valid;
  end

  zep_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .word_in   (link[NCELL]),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data),
    .busy      (emit_busy)
  );

endmodule

// ----- design/zep_checker.sv -----
// ----------------------------------------------------------------------------
// zep_checker
// Port-level checks of the zone edge proximity engine, bound to the top level.
// ----------------------------------------------------------------------------
module zep_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         in_op,
  input logic               out_valid,
  input logic               out_ready,
  input zep_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.last)
    else $error("not-found result without last");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      (out_data.result_index == 4'd0) && (out_data.bound_x == 16'sd0) &&
      (out_data.bound_y == 16'sd0) && (out_data.bound_w == 16'd0) &&
      (out_data.bound_h == 16'd0))
    else $error("not-found result with nonzero fields");

  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
      ((in_op == zep_pkg::OP_QUERY) || (in_op == zep_pkg::OP_BOUNDS)) |=> !in_ready)
    else $error("input taken during a scan");

endmodule

bind zone_edge_proximity_engine zep_checker u_zep_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.data.op),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the zone edge proximity engine. A queue-fed driver
// sends load, query and bounds words in random bursts while the result side
// stalls on its own pattern. Every accepted word runs through an in-bench
// model of the zone table. Each result word is checked field by field against
// the oldest predicted reply. Register settings change only while the block
// is idle. The run covers the field extremes, zero and saturating thresholds,
// empty and skipped masks, and near-edge hits.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 50;
  localparam int SLOTS = zep_pkg::ZONE_SLOTS;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLIC} rx_mode_t;
  typedef enum int {SIDE_LEFT, SIDE_RIGHT, SIDE_TOP, SIDE_BOTTOM} edge_side_t;

  logic clk;
  logic rst_n;

  zep_stream_if #(.T(zep_pkg::in_word_t))  in_if ();
  zep_stream_if #(.T(zep_pkg::out_word_t)) out_if ();
  zep_stream_if #(.T(zep_pkg::cfg_word_t)) cfg_if ();

  zone_edge_proximity_engine #(.MAX_ZONES(SLOTS)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  // model state, updated on accepted words
  logic signed [15:0] tbl_left [SLOTS];
  logic signed [15:0] tbl_top  [SLOTS];
  logic [14:0]        tbl_wide [SLOTS];
  logic [14:0]        tbl_tall [SLOTS];
  logic [4:0]         cur_count;
  logic [14:0]        cur_threshold;
  zep_pkg::out_word_t due_results [$];

  // stimulus-side copy of the table, updated when a load is queued
  logic signed [15:0] plan_left [SLOTS];
  logic signed [15:0] plan_top  [SLOTS];
  logic [14:0]        plan_wide [SLOTS];
  logic [14:0]        plan_tall [SLOTS];
  int                 plan_threshold;

  zep_pkg::in_word_t input_backlog [$];
  int       words_in_flight = 0;
  logic     in_taken = 1'b0;
  int       burst_left = 8;
  int       gap_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;
  int       quiet_cycles = 0;

  int n_errors = 0;
  int n_results = 0;
  int n_loads = 0;
  int n_queries = 0;
  int n_hits = 0;
  int n_bounds = 0;
  int n_ignored = 0;
  int n_settings = 0;

  always #5 clk = ~clk;

  function automatic int active_zones();
    return (cur_count > 5'(SLOTS)) ? SLOTS : int'(cur_count);
  endfunction

  function automatic bit edge_close(input int a, input int b);
    int d;
    d = a - b;
    if (d < 0) d = -d;
    return d < int'(cur_threshold);
  endfunction

  function automatic void compute_zone_replies(input zep_pkg::in_word_t w);
    int n, l, t, r, b, px, py, mnx, mny, mxx, mxy, span_w, span_h;
    bit any;
    zep_pkg::out_word_t rep;
    zep_pkg::out_word_t hits [$];
    n = active_zones();
    px = int'(w.coord_x);
    py = int'(w.coord_y);
    rep = '0;
    case (w.op)
      zep_pkg::OP_LOAD: begin
        tbl_left[w.zone_index] = w.coord_x;
        tbl_top[w.zone_index]  = w.coord_y;
        tbl_wide[w.zone_index] = w.extent_w;
        tbl_tall[w.zone_index] = w.extent_h;
        n_loads++;
      end
      zep_pkg::OP_QUERY: begin
        n_queries++;
        for (int i = 0; i < n; i++) begin
          l = int'(tbl_left[i]);
          t = int'(tbl_top[i]);
          r = l + int'(tbl_wide[i]);
          b = t + int'(tbl_tall[i]);
          if (((edge_close(px, l) || edge_close(px, r)) && py >= t && py <= b) ||
              ((edge_close(py, t) || edge_close(py, b)) && px >= l && px <= r)) begin
            rep = '0;
            rep.result_index = 4'(i);
            rep.found = 1'b1;
            hits.insert(hits.size(), rep);
          end
        end
        if (hits.size() == 0) begin
          rep = '0;
          rep.last = 1'b1;
          due_results.insert(due_results.size(), rep);
        end else begin
          hits[hits.size() - 1].last = 1'b1;
          n_hits += hits.size();
          foreach (hits[k]) due_results.insert(due_results.size(), hits[k]);
        end
      end
      zep_pkg::OP_BOUNDS: begin
        n_bounds++;
        any = 1'b0;
        mnx = 0;
        mny = 0;
        mxx = 0;
        mxy = 0;
        for (int i = 0; i < n; i++) begin
          if (w.zone_mask[i]) begin
            l = int'(tbl_left[i]);
            t = int'(tbl_top[i]);
            r = l + int'(tbl_wide[i]);
            b = t + int'(tbl_tall[i]);
            if (!any) begin
              mnx = l;
              mny = t;
              mxx = r;
              mxy = b;
              any = 1'b1;
            end else begin
              if (l < mnx) mnx = l;
              if (t < mny) mny = t;
              if (r > mxx) mxx = r;
              if (b > mxy) mxy = b;
            end
          end
        end
        rep.last = 1'b1;
        if (any) begin
          span_w = mxx - mnx;
          span_h = mxy - mny;
          if (span_w > 65535) span_w = 65535;
          if (span_h > 65535) span_h = 65535;
          rep.found = 1'b1;
          rep.bound_x = 16'(mnx);
          rep.bound_y = 16'(mny);
          rep.bound_w = 16'(span_w);
          rep.bound_h = 16'(span_h);
        end
        due_results.insert(due_results.size(), rep);
      end
      default: n_ignored++;
    endcase
  endfunction

  function automatic void apply_register(input zep_pkg::cfg_word_t c);
    case (c.reg_index)
      zep_pkg::CFG_ZONE_COUNT:     cur_count = c.value[4:0];
      zep_pkg::CFG_NEAR_THRESHOLD: cur_threshold = c.value[14:0];
      default: ;
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
    if (got_v !== want_v) begin
      n_errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
    end
  endfunction

  function automatic void check_reply(input zep_pkg::out_word_t got);
    zep_pkg::out_word_t want;
    n_results++;
    if (due_results.size() == 0) begin
      n_errors++;
      $display("%0t: unexpected result word: expected none, actual %h", $time, got);
      return;
    end
    want = due_results.pop_front();
    compare_field("result_index", 16'(want.result_index), 16'(got.result_index));
    compare_field("found", 16'(want.found), 16'(got.found));
    compare_field("last", 16'(want.last), 16'(got.last));
    compare_field("bound_x", 16'(want.bound_x), 16'(got.bound_x));
    compare_field("bound_y", 16'(want.bound_y), 16'(got.bound_y));
    compare_field("bound_w", want.bound_w, got.bound_w);
    compare_field("bound_h", want.bound_h, got.bound_h);
  endfunction

  // monitor: predict on accepted words, check results, watch for a hang
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      cur_count = 5'd0;
      cur_threshold = zep_pkg::THRESHOLD_RESET;
      quiet_cycles = 0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        compute_zone_replies(in_if.data);
        words_in_flight--;
      end
      if (out_if.valid && out_if.ready) check_reply(out_if.data);
      if (cfg_if.valid && cfg_if.ready) apply_register(cfg_if.data);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // driver: bursts of words from the backlog with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (input_backlog.size() > 0) begin
        in_if.data <= input_backlog.pop_front();
        in_if.valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result side: stall in stretches of changing character
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(20, 300);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_COIN:   out_if.ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:   out_if.ready <= ((rx_tick % 7) < 4);
      endcase
    end
  end

  function automatic logic signed [15:0] to_coord(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic zep_pkg::in_word_t noise_word(input logic [1:0] op);
    zep_pkg::in_word_t w;
    w.op = op;
    w.zone_index = 4'($urandom);
    w.coord_x = 16'($urandom);
    w.coord_y = 16'($urandom);
    w.extent_w = 15'($urandom);
    w.extent_h = 15'($urandom);
    w.zone_mask = 16'($urandom);
    return w;
  endfunction

  function automatic zep_pkg::in_word_t query_at(input int x, input int y);
    zep_pkg::in_word_t w;
    w = noise_word(zep_pkg::OP_QUERY);
    w.coord_x = to_coord(x);
    w.coord_y = to_coord(y);
    return w;
  endfunction

  function automatic zep_pkg::in_word_t bounds_of(input logic [15:0] mask);
    zep_pkg::in_word_t w;
    w = noise_word(zep_pkg::OP_BOUNDS);
    w.zone_mask = mask;
    return w;
  endfunction

  task automatic push_word(input zep_pkg::in_word_t w);
    input_backlog.insert(input_backlog.size(), w);
    words_in_flight++;
    if (w.op == zep_pkg::OP_LOAD) begin
      plan_left[w.zone_index] = w.coord_x;
      plan_top[w.zone_index]  = w.coord_y;
      plan_wide[w.zone_index] = w.extent_w;
      plan_tall[w.zone_index] = w.extent_h;
    end
  endtask

  task automatic push_load(input int idx, input int x, input int y, input int wd, input int ht);
    zep_pkg::in_word_t w;
    w = noise_word(zep_pkg::OP_LOAD);
    w.zone_index = 4'(idx);
    w.coord_x = to_coord(x);
    w.coord_y = to_coord(y);
    w.extent_w = 15'(wd);
    w.extent_h = 15'(ht);
    push_word(w);
  endtask

  task automatic push_compact_load(input int idx);
    push_load(idx, int'($urandom_range(0, 1200)) - 600, int'($urandom_range(0, 1200)) - 600,
              $urandom_range(0, 300), $urandom_range(0, 300));
  endtask

  // aim a point at one edge of a zone, mostly inside its span
  task automatic push_edge_query(input int n);
    int i, l, t, r, b, reach, off, along_x, along_y;
    edge_side_t side;
    i = $urandom_range(0, n - 1);
    l = int'(plan_left[i]);
    t = int'(plan_top[i]);
    r = l + int'(plan_wide[i]);
    b = t + int'(plan_tall[i]);
    reach = ((plan_threshold > 150) ? 150 : plan_threshold) + 2;
    off = int'($urandom_range(0, 2 * reach)) - reach;
    along_x = l + int'($urandom_range(0, r - l + 10)) - 5;
    along_y = t + int'($urandom_range(0, b - t + 10)) - 5;
    side = edge_side_t'($urandom_range(0, 3));
    case (side)
      SIDE_LEFT:   push_word(query_at(l + off, along_y));
      SIDE_RIGHT:  push_word(query_at(r + off, along_y));
      SIDE_TOP:    push_word(query_at(along_x, t + off));
      default:     push_word(query_at(along_x, b + off));
    endcase
  endtask

  task automatic settle();
    @(negedge clk);
    while (words_in_flight != 0 || due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [3:0] idx, input int value);
    zep_pkg::cfg_word_t c;
    c.reg_index = idx;
    c.value = 16'(value);
    @(negedge clk);
    cfg_if.data <= c;
    cfg_if.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == zep_pkg::CFG_NEAR_THRESHOLD) plan_threshold = value;
    n_settings++;
  endtask

  initial begin
    int zc, thr, n, pick;
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    plan_threshold = int'(zep_pkg::THRESHOLD_RESET);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, ignored opcode, then fill every entry
    push_word(query_at(0, 0));
    push_word(bounds_of(16'hFFFF));
    push_word(noise_word(OP_UNUSED));
    push_load(0, -32768, -32768, 32767, 32767);
    push_load(1, 32767, 32767, 32767, 32767);
    push_load(2, 0, 0, 0, 0);
    push_load(3, 100, 100, 200, 50);
    for (int i = 4; i < SLOTS; i++) push_compact_load(i);
    settle();

    write_register(zep_pkg::CFG_ZONE_COUNT, SLOTS);
    write_register(zep_pkg::CFG_NEAR_THRESHOLD, 20);
    push_word(query_at(100, 120));
    push_word(query_at(-32768, -32768));
    push_word(query_at(32767, 32767));
    push_word(query_at(300, 150));
    push_word(bounds_of(16'hFFFF));
    push_word(bounds_of(16'h0004));
    push_word(bounds_of(16'h0000));
    settle();

    // zero threshold and masks outside the zones in use
    write_register(zep_pkg::CFG_ZONE_COUNT, 3);
    write_register(zep_pkg::CFG_NEAR_THRESHOLD, 0);
    push_word(query_at(0, 0));
    push_word(bounds_of(16'hFFF8));
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) zc = SLOTS;
      else if (ph == 4) zc = 0;
      else if (ph == RANDOM_PHASES - 1) zc = 31;
      else zc = $urandom_range(1, SLOTS);
      if (ph == 1) thr = 32767;
      else if (ph == 3) thr = 1;
      else if (ph == 5) thr = 0;
      else if (ph == 6) thr = $urandom_range(0, 32767);
      else thr = $urandom_range(2, 200);
      write_register(zep_pkg::CFG_ZONE_COUNT, zc);
      write_register(zep_pkg::CFG_NEAR_THRESHOLD, thr);
      n = (zc > SLOTS) ? SLOTS : zc;
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
          if ($urandom_range(0, 9) == 0) push_word(noise_word(zep_pkg::OP_LOAD));
          else push_compact_load($urandom_range(0, SLOTS - 1));
        end else if (pick < 60 && n > 0) begin
          push_edge_query(n);
        end else if (pick < 75) begin
          if ($urandom_range(0, 1) == 0) push_word(noise_word(zep_pkg::OP_QUERY));
          else push_word(query_at(int'($urandom_range(0, 1400)) - 700,
                                  int'($urandom_range(0, 1400)) - 700));
        end else if (pick < 95) begin
          if ($urandom_range(0, 3) == 0)
            push_word(bounds_of(16'(1) << $urandom_range(0, SLOTS - 1)));
          else push_word(noise_word(zep_pkg::OP_BOUNDS));
        end else begin
          push_word(noise_word(OP_UNUSED));
        end
      end
      settle();
    end

    $display("Covered %0d loads, %0d queries with %0d zone hits, %0d bounds words, %0d ignored",
             n_loads, n_queries, n_hits, n_bounds, n_ignored);
    $display("Checked %0d result words over %0d register writes, %0d mismatches",
             n_results, n_settings, n_errors);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- zone_edge_proximity_engine.f -----
design/zep_pkg.sv
design/zep_stream_if.sv
design/zep_cell.sv
design/zep_emit.sv
design/zone_edge_proximity_engine.sv
design/zep_checker.sv
sim/tb_top.sv
